[rtl/core/lkt_pkg.sv]
package lkt_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int KEY_BITS    = 64;
  localparam int VALUE_BITS  = 32;

  localparam int OP_W  = 3;
  localparam int CAP_W = 5;
  localparam int OCC_W = 5;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_FIND             = 3'd0,
    OP_GET_OR_CREATE    = 3'd1,
    OP_INSERT_OR_ASSIGN = 3'd2,
    OP_ERASE            = 3'd3,
    OP_EVICT_LRU        = 3'd4,
    OP_CLEAR            = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic exec;
  } cmd_t;

endpackage

[rtl/core/lkt_ctrl.sv]
module lkt_ctrl
  import lkt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic out_stall_i,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
      end
      S_EXEC: begin
        cmd_o.exec = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // hold the result until taken, reload on execute
  assign out_valid_d = cmd_o.exec | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_exec_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> ($past(state_q) == S_LOOK || $past(state_q) == S_EXEC))
    else $error("execute not preceded by look-up");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EXEC))
    else $error("result raised outside execute");
`endif

endmodule

[rtl/core/lkt_dpath.sv]
module lkt_dpath
  import lkt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_in_i,
  output logic                  found_o,
  output logic [VALUE_BITS-1:0] value_out_o,
  output logic                  inserted_o,
  output logic                  evicted_o,
  output logic [KEY_BITS-1:0]   evicted_key_o,
  output logic [VALUE_BITS-1:0] evicted_value_o,
  output logic [OCC_W-1:0]      occupancy_o
);

  function automatic logic [IDX_W-1:0] first_set(input logic [SLOT_COUNT-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  logic [CAP_W-1:0]       cap_q;
  logic [SLOT_COUNT-1:0]  valid_q, valid_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [KEY_BITS-1:0]    key_q   [SLOT_COUNT];
  logic [KEY_BITS-1:0]    key_d   [SLOT_COUNT];
  logic [VALUE_BITS-1:0]  val_q   [SLOT_COUNT];
  logic [VALUE_BITS-1:0]  val_d   [SLOT_COUNT];
  logic [AGE_W-1:0]       age_q   [SLOT_COUNT];
  logic [AGE_W-1:0]       age_d   [SLOT_COUNT];

  op_e                    op_q;
  logic [KEY_BITS-1:0]    in_key_q;
  logic [VALUE_BITS-1:0]  in_val_q;

  logic                   hit_q, old_any_q, evict_need_q;
  logic [IDX_W-1:0]       sel_q, free_q;

  logic [SLOT_COUNT-1:0]  hit_vec, old_vec, free_vec;
  logic [CNT_W-1:0]       cnt_m1;
  logic [CMP_W-1:0]       cap_ext, lim;
  logic                   hit_any, old_any, evict_need;
  logic [IDX_W-1:0]       hit_idx, old_idx;

  logic                   found_q, ins_q, ev_q;
  logic [VALUE_BITS-1:0]  vout_q, evalue_q;
  logic [KEY_BITS-1:0]    ekey_q;
  logic [OCC_W-1:0]       occ_q;

  logic                   found_d, ins_d, ev_d;
  logic [VALUE_BITS-1:0]  vout_d, evalue_d, wr_val;
  logic [KEY_BITS-1:0]    ekey_d;

  logic [AGE_W-1:0]       sel_age;
  logic [KEY_BITS-1:0]    sel_key;
  logic [VALUE_BITS-1:0]  sel_val;

  // look-up: parallel compare over all slots
  always_comb begin
    cnt_m1 = count_q - CNT_W'(1);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == in_key_q);
      old_vec[i] = valid_q[i] && (age_q[i] == cnt_m1[AGE_W-1:0]);
    end
    hit_any = |hit_vec;
    old_any = |old_vec;
    hit_idx = first_set(hit_vec);
    old_idx = first_set(old_vec);
    cap_ext = CMP_W'(cap_q);
    if (cap_q == '0) begin
      lim = CMP_W'(1);
    end else if (cap_ext > CMP_W'(SLOT_COUNT)) begin
      lim = CMP_W'(SLOT_COUNT);
    end else begin
      lim = cap_ext;
    end
    evict_need = CMP_W'(count_q) >= lim;
    free_vec   = ~valid_q | (evict_need ? old_vec : '0);
  end

  // execute: one table update per item
  always_comb begin
    valid_d  = valid_q;
    count_d  = count_q;
    key_d    = key_q;
    val_d    = val_q;
    age_d    = age_q;
    found_d  = 1'b0;
    ins_d    = 1'b0;
    ev_d     = 1'b0;
    vout_d   = '0;
    ekey_d   = '0;
    evalue_d = '0;
    wr_val   = '0;
    sel_age  = age_q[sel_q];
    sel_key  = key_q[sel_q];
    sel_val  = val_q[sel_q];
    if (cmd_i.exec) begin
      case (op_q)
        OP_FIND, OP_GET_OR_CREATE, OP_INSERT_OR_ASSIGN: begin
          if (hit_q) begin
            wr_val = (op_q == OP_INSERT_OR_ASSIGN) ? in_val_q : sel_val;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (valid_q[i] && (age_q[i] < sel_age)) begin
                age_d[i] = age_q[i] + AGE_W'(1);
              end
            end
            age_d[sel_q] = '0;
            val_d[sel_q] = wr_val;
            found_d      = 1'b1;
            vout_d       = wr_val;
          end else if (op_q != OP_FIND) begin
            if (evict_need_q && old_any_q) begin
              ev_d           = 1'b1;
              ekey_d         = sel_key;
              evalue_d       = sel_val;
              valid_d[sel_q] = 1'b0;
            end else begin
              count_d = count_q + CNT_W'(1);
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (valid_q[i]) begin
                age_d[i] = age_q[i] + AGE_W'(1);
              end
            end
            valid_d[free_q] = 1'b1;
            key_d[free_q]   = in_key_q;
            val_d[free_q]   = in_val_q;
            age_d[free_q]   = '0;
            ins_d           = 1'b1;
            vout_d          = in_val_q;
          end
        end
        OP_ERASE, OP_EVICT_LRU: begin
          if ((op_q == OP_ERASE) ? hit_q : old_any_q) begin
            found_d = 1'b1;
            if (op_q == OP_ERASE) begin
              vout_d = sel_val;
            end else begin
              ev_d     = 1'b1;
              ekey_d   = sel_key;
              evalue_d = sel_val;
            end
            valid_d[sel_q] = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (valid_q[i] && (age_q[i] > sel_age)) begin
                age_d[i] = age_q[i] - AGE_W'(1);
              end
            end
            count_d = count_q - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          valid_d = '0;
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      valid_q      <= '0;
      count_q      <= '0;
      hit_q        <= 1'b0;
      old_any_q    <= 1'b0;
      evict_need_q <= 1'b0;
      sel_q        <= '0;
      free_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      valid_q <= valid_d;
      count_q <= count_d;
      if (cmd_i.lookup) begin
        hit_q        <= hit_any;
        old_any_q    <= old_any;
        evict_need_q <= evict_need;
        free_q       <= first_set(free_vec);
        if (hit_any && (op_q == OP_FIND || op_q == OP_GET_OR_CREATE ||
                        op_q == OP_INSERT_OR_ASSIGN || op_q == OP_ERASE)) begin
          sel_q <= hit_idx;
        end else begin
          sel_q <= old_idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
    age_q <= age_d;
    if (cmd_i.capture) begin
      op_q     <= op_e'(opcode_i);
      in_key_q <= key_i;
      in_val_q <= value_in_i;
    end
    if (cmd_i.exec) begin
      found_q  <= found_d;
      vout_q   <= vout_d;
      ins_q    <= ins_d;
      ev_q     <= ev_d;
      ekey_q   <= ekey_d;
      evalue_q <= evalue_d;
      occ_q    <= count_d[OCC_W-1:0];
    end
  end

  assign found_o         = found_q;
  assign value_out_o     = vout_q;
  assign inserted_o      = ins_q;
  assign evicted_o       = ev_q;
  assign evicted_key_o   = ekey_q;
  assign evicted_value_o = evalue_q;
  assign occupancy_o     = occ_q;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count disagrees with valid slots");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= SLOT_COUNT)
    else $error("entry count above table size");
`endif

endmodule

[rtl/core/lru_keyed_table.sv]
// Channel  Direction  Handshake                  Payload
// in       sink       in_valid_i / in_stall_o    opcode_i, key_i, value_in_i
// out      source     out_valid_o / out_stall_i  found_o, value_out_o, inserted_o,
//                                                evicted_o, evicted_key_o,
//                                                evicted_value_o, occupancy_o
// cfg      sink       cfg_we_i                   cfg_wdata_i (capacity)
//
// Each item passes accept, parallel key compare over all slots, then table update
// with the result loaded into the output register; no new item is accepted until
// that update. The next item is taken while the result waits to be taken.
// Reset empties the table at once and sets capacity to 16; no clearing pass.
// A stalled result holds execution of the following item until it is taken.
module lru_keyed_table
  import lkt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [VALUE_BITS-1:0] value_out_o,
  output logic                  inserted_o,
  output logic                  evicted_o,
  output logic [KEY_BITS-1:0]   evicted_key_o,
  output logic [VALUE_BITS-1:0] evicted_value_o,
  output logic [OCC_W-1:0]      occupancy_o
);

  cmd_t cmd;

  lkt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  lkt_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .key_i           (key_i),
    .value_in_i      (value_in_i),
    .found_o         (found_o),
    .value_out_o     (value_out_o),
    .inserted_o      (inserted_o),
    .evicted_o       (evicted_o),
    .evicted_key_o   (evicted_key_o),
    .evicted_value_o (evicted_value_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

[test/tb_lru_keyed_table.sv]
`timescale 1ns / 100ps

module tb_lru_keyed_table;
  import lkt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int KEY_POOL    = 24;

  localparam logic [OP_W-1:0]       OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0]       OP_SPARE_7 = 3'd7;
  localparam logic [KEY_BITS-1:0]   KEY_ONES   = '1;
  localparam logic [KEY_BITS-1:0]   KEY_MIXED  = 64'h0123_4567_89ab_cdef;
  localparam logic [VALUE_BITS-1:0] VAL_ONES   = '1;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic                  inserted;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
    logic [VALUE_BITS-1:0] evicted_value;
    logic [OCC_W-1:0]      occupancy;
  } result_t;

  class lru_scoreboard;
    logic [CAP_W-1:0]      cap_reg;
    bit                    in_use[SLOT_COUNT];
    logic [KEY_BITS-1:0]   slot_keys[SLOT_COUNT];
    logic [VALUE_BITS-1:0] slot_vals[SLOT_COUNT];
    int unsigned           rank[SLOT_COUNT];
    int unsigned           held;
    result_t               pend;
    result_t               expected_q[$];
    int                    errors;
    int                    items;
    int                    hits;
    int                    inserts;
    int                    evictions;

    function new();
      cap_reg = CAP_RESET;
      held    = 0;
      foreach (in_use[i]) in_use[i] = 1'b0;
      errors = 0; items = 0; hits = 0; inserts = 0; evictions = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      cap_reg = cap;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned cap_limit();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > SLOT_COUNT) c = SLOT_COUNT;
      return c;
    endfunction

    function int match_slot(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < SLOT_COUNT; i++)
        if (in_use[i] && slot_keys[i] == key) return i;
      return -1;
    endfunction

    function void promote(int s);
      int unsigned a;
      a = rank[s];
      for (int i = 0; i < SLOT_COUNT; i++)
        if (in_use[i] && rank[i] < a) rank[i]++;
      rank[s] = 0;
    endfunction

    function void remove_slot(int s);
      int unsigned a;
      a = rank[s];
      in_use[s] = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++)
        if (in_use[i] && rank[i] > a) rank[i]--;
      if (held > 0) held--;
    endfunction

    function int lru_slot();
      int best;
      best = -1;
      for (int i = 0; i < SLOT_COUNT; i++)
        if (in_use[i] && (best < 0 || rank[i] > rank[best])) best = i;
      return best;
    endfunction

    function void insert_entry(logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] val);
      int v;
      int s;
      s = -1;
      if (held >= cap_limit()) begin
        v = lru_slot();
        if (v >= 0) begin
          pend.evicted       = 1'b1;
          pend.evicted_key   = slot_keys[v];
          pend.evicted_value = slot_vals[v];
          remove_slot(v);
          evictions++;
        end
      end
      for (int i = 0; i < SLOT_COUNT; i++)
        if (!in_use[i] && s < 0) s = i;
      if (s < 0) return;
      for (int i = 0; i < SLOT_COUNT; i++)
        if (in_use[i]) rank[i]++;
      in_use[s]    = 1'b1;
      slot_keys[s] = key;
      slot_vals[s] = val;
      rank[s]      = 0;
      held++;
      pend.value_out = val;
      pend.inserted  = 1'b1;
      inserts++;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
                            logic [VALUE_BITS-1:0] val);
      int s;
      pend = '0;
      case (op)
        OP_FIND, OP_GET_OR_CREATE, OP_INSERT_OR_ASSIGN: begin
          s = match_slot(key);
          if (s >= 0) begin
            if (op == OP_INSERT_OR_ASSIGN) slot_vals[s] = val;
            promote(s);
            pend.found     = 1'b1;
            pend.value_out = slot_vals[s];
            hits++;
          end else if (op != OP_FIND) begin
            insert_entry(key, val);
          end
        end
        OP_ERASE: begin
          s = match_slot(key);
          if (s >= 0) begin
            pend.found     = 1'b1;
            pend.value_out = slot_vals[s];
            remove_slot(s);
          end
        end
        OP_EVICT_LRU: begin
          s = lru_slot();
          if (s >= 0) begin
            pend.found         = 1'b1;
            pend.evicted       = 1'b1;
            pend.evicted_key   = slot_keys[s];
            pend.evicted_value = slot_vals[s];
            remove_slot(s);
            evictions++;
          end
        end
        OP_CLEAR: begin
          foreach (in_use[i]) in_use[i] = 1'b0;
          held = 0;
        end
        default: begin
        end
      endcase
      pend.occupancy = OCC_W'(held);
      expected_q.insert(expected_q.size(), pend);
      items++;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h (%0d results pending)",
               what, got, want, expected_q.size());
      errors++;
    endtask

    task compare_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(got.value_out), 0);
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      compare_field("found", 64'(got.found), 64'(want.found));
      compare_field("value_out", 64'(got.value_out), 64'(want.value_out));
      compare_field("inserted", 64'(got.inserted), 64'(want.inserted));
      compare_field("evicted", 64'(got.evicted), 64'(want.evicted));
      compare_field("evicted_key", got.evicted_key, want.evicted_key);
      compare_field("evicted_value", 64'(got.evicted_value), 64'(want.evicted_value));
      compare_field("occupancy", 64'(got.occupancy), 64'(want.occupancy));
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       opcode_i    = '0;
  logic [KEY_BITS-1:0]   key_i       = '0;
  logic [VALUE_BITS-1:0] value_in_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  found_o;
  logic [VALUE_BITS-1:0] value_out_o;
  logic                  inserted_o;
  logic                  evicted_o;
  logic [KEY_BITS-1:0]   evicted_key_o;
  logic [VALUE_BITS-1:0] evicted_value_o;
  logic [OCC_W-1:0]      occupancy_o;

  lru_scoreboard sb = new();

  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  int                  cycle_count   = 0;
  int                  cap_writes    = 0;
  logic [KEY_BITS-1:0] key_pool[KEY_POOL];

  lru_keyed_table i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .key_i          (key_i),
    .value_in_i     (value_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .value_out_o    (value_out_o),
    .inserted_o     (inserted_o),
    .evicted_o      (evicted_o),
    .evicted_key_o  (evicted_key_o),
    .evicted_value_o(evicted_value_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({found_o, value_out_o, inserted_o, evicted_o,
                       evicted_key_o, evicted_value_o, occupancy_o});
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    value_in_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, key, val);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    sb.set_capacity(cap);
    cfg_we_i <= 1'b0;
    cap_writes++;
  endtask

  task automatic send_random_item();
    int                    r;
    logic [OP_W-1:0]       op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
    r = $urandom_range(99);
    if (r < 22)      op = OP_FIND;
    else if (r < 46) op = OP_GET_OR_CREATE;
    else if (r < 68) op = OP_INSERT_OR_ASSIGN;
    else if (r < 83) op = OP_ERASE;
    else if (r < 94) op = OP_EVICT_LRU;
    else if (r < 95) op = OP_CLEAR;
    else if (r < 97) op = ($urandom_range(1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
    else             op = OP_GET_OR_CREATE;
    if ($urandom_range(99) < 3)
      key_pool[$urandom_range(KEY_POOL - 1, 2)] = {$urandom, $urandom};
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
    else                         key = {$urandom, $urandom};
    r = $urandom_range(9);
    if (r == 0)      val = '0;
    else if (r == 1) val = VAL_ONES;
    else             val = $urandom;
    send_item(op, key, val);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      send_random_item();
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 25;
    stall_pct     = 79;

    send_item(OP_FIND, '0, '0);
    send_item(OP_ERASE, KEY_ONES, '0);
    send_item(OP_EVICT_LRU, '0, '0);
    send_item(OP_SPARE_6, KEY_MIXED, VAL_ONES);
    send_item(OP_SPARE_7, KEY_ONES, VAL_ONES);
    send_item(OP_GET_OR_CREATE, '0, '0);
    send_item(OP_GET_OR_CREATE, KEY_ONES, VAL_ONES);
    send_item(OP_GET_OR_CREATE, '0, 32'h5);
    send_item(OP_INSERT_OR_ASSIGN, KEY_ONES, 32'h1234_5678);
    send_item(OP_INSERT_OR_ASSIGN, KEY_MIXED, 32'ha5a5_a5a5);
    send_item(OP_FIND, KEY_ONES, '0);
    send_item(OP_EVICT_LRU, '0, '0);
    send_item(OP_ERASE, KEY_MIXED, '0);
    send_item(OP_ERASE, KEY_MIXED, '0);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_FIND, KEY_ONES, '0);
    write_capacity(CAP_W'(1));
    send_item(OP_GET_OR_CREATE, KEY_MIXED, 32'h1);
    send_item(OP_GET_OR_CREATE, ~KEY_MIXED, 32'h2);
    send_item(OP_INSERT_OR_ASSIGN, ~KEY_MIXED, 32'h3);
    send_item(OP_FIND, KEY_MIXED, '0);

    write_capacity(CAP_W'(16));
    run_random(300);
    write_capacity(CAP_W'(0));
    run_random(100);

    send_idle_pct = 79;
    stall_pct     = 25;
    write_capacity(CAP_W'(31));
    run_random(300);
    write_capacity(CAP_W'(1));
    run_random(100);

    send_idle_pct = 0;
    stall_pct     = 0;
    write_capacity(CAP_W'(3));
    run_random(200);
    repeat (3) begin
      write_capacity(CAP_W'($urandom_range(31)));
      run_random(100);
    end
    write_capacity(CAP_W'(16));
    run_random(400);

    wait_drained();
    repeat (6) @(posedge clk_i);

    $display("Ran %0d items over %0d capacity writes: %0d hits, %0d new entries, %0d evictions",
             sb.items, cap_writes, sb.hits, sb.inserts, sb.evictions);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[lru_keyed_table.f]
rtl/core/lkt_pkg.sv
rtl/core/lkt_ctrl.sv
rtl/core/lkt_dpath.sv
rtl/core/lru_keyed_table.sv
test/tb_lru_keyed_table.sv
